@@ hw/rtl/sam_pkg.sv @@
// ----------------------------------------------------------------------------
// sam_pkg
// shared constants and types of the suffix automaton builder
// ----------------------------------------------------------------------------
package sam_pkg;
  localparam int MAX_CHARS     = 1024;
  localparam int ALPHABET_SIZE = 26;
  localparam int NSTATES       = 2 * MAX_CHARS;
  localparam int SW            = $clog2(NSTATES);
  localparam int CW            = 5;
  localparam int TDEPTH        = NSTATES * 32;
  localparam int TAW           = SW + CW;
  localparam int LW            = 11;
  localparam int NW            = $clog2(MAX_CHARS + 1);

  typedef struct packed {
    logic [LW-1:0] len;
    logic [SW-1:0] link;
  } node_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SKIP, ST_INIT, ST_W1_RD, ST_W1_CHK, ST_Q_RD, ST_Q_CHK,
    ST_CP_RD, ST_CP_WR, ST_W2_RD, ST_W2_CHK, ST_OUT
  } state_t;
endpackage

@@ hw/rtl/suffix_automaton_builder.sv @@
// ----------------------------------------------------------------------------
// suffix_automaton_builder
// online suffix automaton construction, one symbol per beat
// ----------------------------------------------------------------------------
// channel  dir  signals
// in       in   in_valid in_ready in_symbol
// out      out  out_valid out_ready out_new_state .. out_full_flag
// steps: init, a read and a test per state on the suffix link walk, a read of q to test
//   the hit; a clone copies 26 transitions (read, write) and walks the links again; an ignored symbol is skipped
// the transition and node memories are single port, one access each per cycle
// reset: clearing pass over all 65536 transition entries, in_ready low meanwhile
// result register: next item waits until the result beat is taken
module suffix_automaton_builder
  import sam_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [CW-1:0] in_symbol,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [SW-1:0] out_new_state,
  output logic [LW-1:0] out_new_length,
  output logic [SW-1:0] out_new_suffix_link,
  output logic          out_made_clone,
  output logic [SW-1:0] out_clone_index,
  output logic [SW-1:0] out_state_count,
  output logic          out_full_flag
);
  state_t st_r, st_nxt;
  logic [TAW-1:0] clr_r;
  logic [SW-1:0]  used_r, last_r, cur_r, p_r, q_r, clone_r, qlink_r, olink_r;
  logic [NW-1:0]  taken_r;
  logic [CW-1:0]  c_r, k_r;
  logic [LW-1:0]  plen_r, olen_r;
  logic           made_r, full_r;

  logic           t_we, n_we;
  logic [TAW-1:0] t_addr;
  logic [SW-1:0]  t_wd, t_rd, n_addr;
  node_t          n_wd, n_rd;

  sam_ram #(.WIDTH(SW), .DEPTH(TDEPTH)) u_trans (
    .clk(clk), .we(t_we), .addr(t_addr), .wdata(t_wd), .rdata(t_rd));
  sam_ram #(.WIDTH($bits(node_t)), .DEPTH(NSTATES)) u_node (
    .clk(clk), .we(n_we), .addr(n_addr), .wdata(n_wd), .rdata(n_rd));

  logic full_w, bad_w, hit_w, last_k_w;
  assign full_w   = (taken_r >= NW'(MAX_CHARS));
  assign bad_w    = (in_symbol >= CW'(ALPHABET_SIZE));
  assign hit_w    = (plen_r + LW'(1) == n_rd.len);
  assign last_k_w = (k_r == CW'(ALPHABET_SIZE - 1));

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLEAR:  if (clr_r == TAW'(TDEPTH - 1)) st_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid) st_nxt = (full_w || bad_w) ? ST_SKIP : ST_INIT;
      ST_SKIP:   st_nxt = ST_OUT;
      ST_INIT:   st_nxt = ST_W1_RD;
      ST_W1_RD:  st_nxt = ST_W1_CHK;
      ST_W1_CHK: begin
        if (t_rd != '0) st_nxt = ST_Q_RD;
        else if (p_r == '0) st_nxt = ST_OUT;
        else st_nxt = ST_W1_RD;
      end
      ST_Q_RD:   st_nxt = ST_Q_CHK;
      ST_Q_CHK:  st_nxt = hit_w ? ST_OUT : ST_CP_RD;
      ST_CP_RD:  st_nxt = ST_CP_WR;
      ST_CP_WR:  st_nxt = last_k_w ? ST_W2_RD : ST_CP_RD;
      ST_W2_RD:  st_nxt = ST_W2_CHK;
      ST_W2_CHK: st_nxt = (t_rd != q_r || p_r == '0) ? ST_OUT : ST_W2_RD;
      ST_OUT:    if (out_ready) st_nxt = ST_IDLE;
      default:   st_nxt = ST_CLEAR;
    endcase
  end

  // memory port control
  always_comb begin
    t_we   = 1'b0;
    t_addr = {p_r, c_r};
    t_wd   = cur_r;
    n_we   = 1'b0;
    n_addr = last_r;
    n_wd   = '{len: olen_r, link: clone_r};
    unique case (st_r) inside
      ST_CLEAR: begin
        t_we = 1'b1; t_addr = clr_r; t_wd = '0;
        n_we = 1'b1; n_addr = clr_r[SW-1:0]; n_wd = '0;
      end
      ST_INIT: begin
        n_we = 1'b1; n_addr = cur_r; n_wd = '{len: n_rd.len + LW'(1), link: '0};
      end
      ST_W1_RD, ST_W2_RD: n_addr = p_r;
      ST_W1_CHK: t_we = (t_rd == '0);
      ST_Q_RD: n_addr = q_r;
      ST_Q_CHK: begin
        n_we = 1'b1;
        if (hit_w) begin
          n_addr = cur_r; n_wd = '{len: olen_r, link: q_r};
        end else begin
          n_addr = q_r; n_wd = '{len: n_rd.len, link: used_r};
        end
      end
      ST_CP_RD: begin
        t_addr = {q_r, k_r};
        n_we = (k_r == '0); n_addr = clone_r;
        n_wd = '{len: plen_r + LW'(1), link: qlink_r};
      end
      ST_CP_WR: begin
        t_we = 1'b1; t_addr = {clone_r, k_r}; t_wd = t_rd;
        n_we = (k_r == '0); n_addr = cur_r; n_wd = '{len: olen_r, link: clone_r};
      end
      ST_W2_CHK: begin
        t_we = (t_rd == q_r); t_wd = clone_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR; clr_r <= '0; used_r <= SW'(1); last_r <= '0; taken_r <= '0;
      cur_r <= '0; p_r <= '0; q_r <= '0; clone_r <= '0; qlink_r <= '0; olink_r <= '0;
      c_r <= '0; k_r <= '0; plen_r <= '0; olen_r <= '0; made_r <= 1'b0; full_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        ST_CLEAR: clr_r <= clr_r + TAW'(1);
        ST_IDLE: if (in_valid) begin
          c_r <= in_symbol; made_r <= 1'b0; clone_r <= '0; full_r <= full_w;
          if (full_w || bad_w) begin
            cur_r <= last_r;
          end else begin
            cur_r <= used_r; used_r <= used_r + SW'(1);
            taken_r <= taken_r + NW'(1); p_r <= last_r;
          end
        end
        ST_SKIP: begin
          olen_r <= n_rd.len; olink_r <= n_rd.link;
        end
        ST_INIT: begin
          olen_r <= n_rd.len + LW'(1); olink_r <= '0;
        end
        ST_W1_CHK: begin
          if (t_rd != '0) begin
            q_r <= t_rd; plen_r <= n_rd.len;
          end else begin
            p_r <= n_rd.link;
          end
        end
        ST_Q_CHK: begin
          k_r <= '0;
          if (hit_w) begin
            olink_r <= q_r;
          end else begin
            clone_r <= used_r; used_r <= used_r + SW'(1); made_r <= 1'b1;
            qlink_r <= n_rd.link; olink_r <= used_r;
          end
        end
        ST_CP_WR: k_r <= k_r + CW'(1);
        ST_W2_CHK: p_r <= n_rd.link;
        ST_OUT: if (out_ready) last_r <= cur_r;
        default: ;
      endcase
    end
  end

  assign in_ready            = (st_r == ST_IDLE);
  assign out_valid           = (st_r == ST_OUT);
  assign out_new_state       = cur_r;
  assign out_new_length      = olen_r;
  assign out_new_suffix_link = olink_r;
  assign out_made_clone      = made_r;
  assign out_clone_index     = clone_r;
  assign out_state_count     = used_r;
  assign out_full_flag       = full_r;

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid));
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({out_new_state, out_new_length,
      out_new_suffix_link, out_made_clone, out_clone_index, out_state_count,
      out_full_flag}));
  a_clone_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_made_clone == (out_clone_index != '0)));
  a_state_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_new_state < out_state_count));
  a_taken: assert property (@(posedge clk) disable iff (!rst_n)
    taken_r <= NW'(MAX_CHARS));
endmodule

@@ hw/rtl/sam_ram.sv @@
// ----------------------------------------------------------------------------
// sam_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module sam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

@@ sim/tb_suffix_automaton_builder.sv @@
// ----------------------------------------------------------------------------
// tb_suffix_automaton_builder
// feeds symbol beats through a directed table and then random strings, predicts
// each result with a local model of the online suffix automaton or takes it from
// the table row, and checks the result beats in order; random stalls on both channels
// ----------------------------------------------------------------------------
module tb_suffix_automaton_builder
  import sam_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [10:0] new_state;
    logic [10:0] new_length;
    logic [10:0] new_suffix_link;
    logic        made_clone;
    logic [10:0] clone_index;
    logic [10:0] state_count;
    logic        full_flag;
  } sam_result_t;

  typedef struct packed {
    logic [4:0]  sym;
    logic        typed;
    sam_result_t res;
  } sym_row_t;

  localparam int WATCHDOG_LIMIT = 300000;
  localparam int LONG_HOLD      = 3000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [4:0]  in_symbol;
  logic        out_valid;
  logic        out_ready;
  logic [10:0] out_new_state;
  logic [10:0] out_new_length;
  logic [10:0] out_new_suffix_link;
  logic        out_made_clone;
  logic [10:0] out_clone_index;
  logic [10:0] out_state_count;
  logic        out_full_flag;

  suffix_automaton_builder dut (.*);

  // local model state
  logic [10:0] m_len [NSTATES];
  logic [10:0] m_link[NSTATES];
  logic [10:0] m_next[NSTATES][ALPHABET_SIZE];
  int          m_used;
  int          m_last;
  int          m_taken;

  sam_result_t pending_q[$];
  int          mismatches;
  int          idle_cycles;
  bit          hold_request;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic sam_result_t report(int st, bit made, int cl, bit full);
    sam_result_t r;
    r.new_state       = st[10:0];
    r.new_length      = m_len[st];
    r.new_suffix_link = m_link[st];
    r.made_clone      = made;
    r.clone_index     = cl[10:0];
    r.state_count     = m_used[10:0];
    r.full_flag       = full;
    return r;
  endfunction

  function automatic sam_result_t extend_automaton(logic [4:0] sym);
    int c, cur, p, q, cl;
    bit made;
    made = 0;
    cl = 0;
    if (m_taken >= MAX_CHARS) return report(m_last, 0, 0, 1);
    if (sym >= ALPHABET_SIZE) return report(m_last, 0, 0, 0);
    c = sym;
    m_taken++;
    cur = m_used++;
    m_len[cur] = m_len[m_last] + 11'd1;
    m_link[cur] = '0;
    p = m_last;
    while (m_next[p][c] == 0) begin
      m_next[p][c] = cur[10:0];
      if (p == 0) break;
      p = m_link[p];
    end
    if (m_next[p][c] != 0 && m_next[p][c] != cur[10:0]) begin
      q = m_next[p][c];
      if (m_len[p] + 11'd1 == m_len[q]) begin
        m_link[cur] = q[10:0];
      end else begin
        cl = m_used++;
        made = 1;
        m_len[cl] = m_len[p] + 11'd1;
        for (int k = 0; k < ALPHABET_SIZE; k++) m_next[cl][k] = m_next[q][k];
        m_link[cl] = m_link[q];
        m_link[q] = cl[10:0];
        m_link[cur] = cl[10:0];
        while (m_next[p][c] == q[10:0]) begin
          m_next[p][c] = cl[10:0];
          if (p == 0) break;
          p = m_link[p];
        end
      end
    end
    m_last = cur;
    return report(cur, made, cl, 0);
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  task automatic send_symbol(logic [4:0] sym, bit typed, sam_result_t typed_res);
    sam_result_t r;
    int g;
    in_valid  <= 1'b1;
    in_symbol <= sym;
    do @(posedge clk); while (!in_ready);
    r = extend_automaton(sym);
    pending_q.insert(pending_q.size(), typed ? typed_res : r);
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // receiver stalls
  initial begin
    int n;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_request) begin
        hold_request = 0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_ready <= 1'b1;
      n = $urandom_range(0, 99) < 30 ? 0 : $urandom_range(1, 12);
      repeat (n) @(posedge clk);
      n = gap_len();
      if (n != 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        @(posedge clk);
      end
    end
  end

  // result check
  always @(posedge clk) begin
    sam_result_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_new_state, out_new_length, out_new_suffix_link, out_made_clone,
              out_clone_index, out_state_count, out_full_flag};
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = pending_q.pop_front();
        if (got.new_state !== want.new_state || got.new_length !== want.new_length ||
            got.new_suffix_link !== want.new_suffix_link ||
            got.made_clone !== want.made_clone || got.clone_index !== want.clone_index ||
            got.state_count !== want.state_count || got.full_flag !== want.full_flag) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch exp %p got %p", want, got);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    sym_row_t rows[$];
    int alpha, r;
    logic [4:0] s;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_symbol = '0;
    mismatches = 0;
    idle_cycles = 0;
    hold_request = 0;
    for (int i = 0; i < NSTATES; i++) begin
      m_len[i] = '0;
      m_link[i] = '0;
      for (int k = 0; k < ALPHABET_SIZE; k++) m_next[i][k] = '0;
    end
    m_used = 1;
    m_last = 0;
    m_taken = 0;

    rows = '{
      '{5'd0,  1'b1, '{11'd1, 11'd1, 11'd0, 1'b0, 11'd0, 11'd2, 1'b0}},
      '{5'd31, 1'b1, '{11'd1, 11'd1, 11'd0, 1'b0, 11'd0, 11'd2, 1'b0}},
      '{5'd26, 1'b1, '{11'd1, 11'd1, 11'd0, 1'b0, 11'd0, 11'd2, 1'b0}},
      '{5'd0,  1'b1, '{11'd2, 11'd2, 11'd1, 1'b0, 11'd0, 11'd3, 1'b0}},
      '{5'd1,  1'b0, '0}, '{5'd0, 1'b0, '0}, '{5'd1, 1'b0, '0},
      '{5'd1,  1'b0, '0}, '{5'd0, 1'b0, '0}, '{5'd25, 1'b0, '0},
      '{5'd16, 1'b0, '0}, '{5'd15, 1'b0, '0}, '{5'd0, 1'b0, '0},
      '{5'd0,  1'b0, '0}, '{5'd25, 1'b0, '0}, '{5'd25, 1'b0, '0},
      '{5'd30, 1'b0, '0}, '{5'd8,  1'b0, '0}, '{5'd0, 1'b0, '0}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) send_symbol(rows[i].sym, rows[i].typed, rows[i].res);

    alpha = 2;
    for (int i = 0; i < 1530; i++) begin
      if (i % 150 == 0) alpha = $urandom_range(2, 4);
      if (i == 300) hold_request = 1;
      if (i == 800) begin
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 65) s = $urandom_range(0, alpha - 1);
      else if (r < 95) s = $urandom_range(0, ALPHABET_SIZE - 1);
      else s = $urandom_range(ALPHABET_SIZE, 31);
      send_symbol(s, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
